/* hw/rtl/rti_pkg.sv */
// Shared types, constants and symbol tables for the Roman numeral encoder.
package rti_pkg;

	localparam int VALUE_W = 12;
	localparam int CHAR_W = 8;
	localparam int DIGIT_W = 4;
	localparam int NUM_DIGITS = 4;
	localparam int POS_W = 2;
	localparam int SYM_W = 3;
	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	// Symbol indexes, in order of increasing weight.
	localparam logic [SYM_W-1:0] SYM_I = 3'd0;
	localparam logic [SYM_W-1:0] SYM_V = 3'd1;
	localparam logic [SYM_W-1:0] SYM_X = 3'd2;
	localparam logic [SYM_W-1:0] SYM_L = 3'd3;
	localparam logic [SYM_W-1:0] SYM_C = 3'd4;
	localparam logic [SYM_W-1:0] SYM_D = 3'd5;
	localparam logic [SYM_W-1:0] SYM_M = 3'd6;

	// Decimal digits of one value, index 3 is thousands and index 0 is ones.
	typedef struct packed {
		logic err;
		logic zero;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] dig;
	} rti_digits_t;

	function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			SYM_I: c = 8'h49;
			SYM_V: c = 8'h56;
			SYM_X: c = 8'h58;
			SYM_L: c = 8'h4C;
			SYM_C: c = 8'h43;
			SYM_D: c = 8'h44;
			SYM_M: c = 8'h4D;
			default: c = 8'h4D;
		endcase
		return c;
	endfunction

	// Number of characters that one decimal digit expands to.
	function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [2:0] n;
		case (d)
			4'd0: n = 3'd0;
			4'd1: n = 3'd1;
			4'd2: n = 3'd2;
			4'd3: n = 3'd3;
			4'd4: n = 3'd2;
			4'd5: n = 3'd1;
			4'd6: n = 3'd2;
			4'd7: n = 3'd3;
			4'd8: n = 3'd4;
			4'd9: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

/* hw/rtl/rti_digit_split.sv */
// Splits a registered value into its four decimal digits and flags zero and out-of-range values.
module rti_digit_split (
	input  logic [rti_pkg::VALUE_W-1:0] value,
	output rti_pkg::rti_digits_t        digits
);

	logic [1:0]  thou;
	logic [3:0]  hund;
	logic [3:0]  tens;
	logic [9:0]  rem1;
	logic [6:0]  rem2;
	logic [3:0]  rem3;
	logic [11:0] sub1;
	logic [9:0]  sub2;
	logic [6:0]  sub3;

	// Each digit is found by comparing the running remainder against its multiples.
	always_comb begin
		thou = 2'd0;
		for (int i = 1; i <= 3; i++) begin
			if (value >= 12'(i * 1000)) begin
				thou = 2'(i);
			end
		end
		sub1 = 12'(thou) * 12'd1000;
		rem1 = 10'(value - sub1);

		hund = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (rem1 >= 10'(i * 100)) begin
				hund = 4'(i);
			end
		end
		sub2 = 10'(hund) * 10'd100;
		rem2 = 7'(rem1 - sub2);

		tens = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (rem2 >= 7'(i * 10)) begin
				tens = 4'(i);
			end
		end
		sub3 = 7'(tens) * 7'd10;
		rem3 = 4'(rem2 - sub3);

		digits.err  = (value > rti_pkg::MAX_VALUE);
		digits.dig  = {{2'b00, thou}, hund, tens, rem3};
		digits.zero = (value == '0);
	end

endmodule

/* hw/rtl/rti_serializer.sv */
// Walks the decimal digits and emits one numeral character per cycle, or one error result.
module rti_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  rti_pkg::rti_digits_t        in_digits,
	output logic                        in_take,
	output logic                        strobe,
	output logic [rti_pkg::CHAR_W-1:0]  char_code,
	output logic                        last,
	output logic                        error
);

	logic [rti_pkg::NUM_DIGITS-1:0][rti_pkg::DIGIT_W-1:0] dig_q;
	logic [rti_pkg::POS_W-1:0] pos_q;
	logic [1:0]                k_q;
	logic                      act_q;
	logic                      err_q;

	logic                      strobe_q;
	logic [rti_pkg::CHAR_W-1:0] char_q;
	logic                      last_q;
	logic                      error_q;

	logic [rti_pkg::DIGIT_W-1:0] cur_dig;
	logic [2:0]                  cur_len;
	logic [rti_pkg::SYM_W-1:0]   one_idx;
	logic [rti_pkg::SYM_W-1:0]   five_idx;
	logic [rti_pkg::SYM_W-1:0]   ten_idx;
	logic [rti_pkg::SYM_W-1:0]   sym_idx;
	logic                        more;
	logic                        found;
	logic [rti_pkg::POS_W-1:0]   nxt_pos;
	logic [rti_pkg::POS_W-1:0]   first_pos;
	logic                        is_last;
	logic                        load;

	always_comb begin
		cur_dig  = dig_q[pos_q];
		cur_len  = rti_pkg::digit_len(cur_dig);
		one_idx  = {pos_q, 1'b0};
		// The thousands place has no five or ten symbol of its own; M stands in.
		five_idx = (pos_q == 2'd3) ? rti_pkg::SYM_M : one_idx + 3'd1;
		ten_idx  = (pos_q == 2'd3) ? rti_pkg::SYM_M : one_idx + 3'd2;

		case (cur_dig)
			4'd4:    sym_idx = (k_q == 2'd0) ? one_idx : five_idx;
			4'd5:    sym_idx = five_idx;
			4'd6,
			4'd7,
			4'd8:    sym_idx = (k_q == 2'd0) ? five_idx : one_idx;
			4'd9:    sym_idx = (k_q == 2'd0) ? one_idx : ten_idx;
			default: sym_idx = one_idx;
		endcase

		more = (({1'b0, k_q} + 3'd1) < cur_len);

		// Next lower place with a nonzero digit; ascending scan keeps the highest.
		found   = 1'b0;
		nxt_pos = '0;
		for (int p = 0; p < rti_pkg::NUM_DIGITS; p++) begin
			if ((2'(p) < pos_q) && (dig_q[p] != '0)) begin
				found   = 1'b1;
				nxt_pos = 2'(p);
			end
		end

		first_pos = '0;
		for (int p = 0; p < rti_pkg::NUM_DIGITS; p++) begin
			if (in_digits.dig[p] != '0) begin
				first_pos = 2'(p);
			end
		end

		is_last = act_q && (err_q || (!more && !found));
		load    = in_valid && (!act_q || is_last);
	end

	assign in_take = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			err_q <= 1'b0;
			pos_q <= '0;
			k_q   <= '0;
		end else if (load) begin
			err_q <= in_digits.err;
			pos_q <= first_pos;
			k_q   <= '0;
			// A zero value produces no characters and leaves the serializer free.
			act_q <= in_digits.err || !in_digits.zero;
		end else if (act_q) begin
			if (is_last) begin
				act_q <= 1'b0;
			end else if (more) begin
				k_q <= k_q + 2'd1;
			end else begin
				pos_q <= nxt_pos;
				k_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= in_digits.dig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		char_q  <= err_q ? '0 : rti_pkg::sym_char(sym_idx);
		last_q  <= is_last;
		error_q <= err_q;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

/* hw/rtl/int_to_roman_encoder.sv */
// Top level of the Roman numeral encoder: input register, digit split and serializer.
// The first character of a transaction passes the input register, the serializer state and the
// output register. Characters follow one per cycle; the serializer takes a new value with the
// last character of the current one, and the input register can hold one value meanwhile.
// A zero value emits nothing; a value above 3999 emits one error result.
// Reset clears all control state asynchronously; the receiver cannot stall the result strobe.
module int_to_roman_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rti_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [rti_pkg::CHAR_W-1:0]  char_code,
	output logic                        last,
	output logic                        error
);

	logic [rti_pkg::VALUE_W-1:0] value_s1;
	logic                        valid_s1;
	rti_pkg::rti_digits_t        digits;
	logic                        take;
	logic                        accept;

	assign busy   = valid_s1 && !take;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= value;
		end
	end

	rti_digit_split u_split (
		.value  (value_s1),
		.digits (digits)
	);

	rti_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_digits (digits),
		.in_take   (take),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last),
		.error     (error)
	);

endmodule
